// ===== rtl/core/moving_stddev_band_trader_defines.svh =====
// ----------------------------------------------------------------------------
// Band trader assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MOVING_STDDEV_BAND_TRADER_DEFINES_SVH
`define MOVING_STDDEV_BAND_TRADER_DEFINES_SVH

// same-cycle implication
`define MSTD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MSTD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/mstd_pkg.sv =====
// ----------------------------------------------------------------------------
// Band trader package
// Fixed widths, register indexes, order codes and sequencer states.
// ----------------------------------------------------------------------------
package mstd_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam int WLEN_W     = 9;
	localparam int LIMIT_W    = 10;
	localparam int MULT_W     = 4;
	localparam int PP_W       = 2 * MULT_W;
	localparam int HOLD_W     = 11;
	localparam int ORDER_W    = 2;
	localparam int CASH_W     = 48;
	localparam int CASH_XW    = 50;
	localparam int OUT_TDATA_W = 104;
	localparam int OUT_PAD_W  = OUT_TDATA_W - ORDER_W - 2 * CASH_W;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND_MULT  = 2'd2;

	localparam logic [WLEN_W-1:0]  WLEN_RST  = 9'd20;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 10'd5;
	localparam logic [MULT_W-1:0]  MULT_RST  = 4'd2;

	localparam logic [ORDER_W-1:0] ORD_NONE = 2'd0;
	localparam logic [ORDER_W-1:0] ORD_BUY  = 2'd1;
	localparam logic [ORDER_W-1:0] ORD_SELL = 2'd2;

	localparam logic signed [CASH_XW-1:0] CASH_XMAX = 50'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [CASH_XW-1:0] CASH_XMIN = 50'sh3_8000_0000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_ACC,
		ST_MUL,
		ST_VAR,
		ST_BAND,
		ST_DECIDE,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/core/moving_stddev_band_trader.sv =====
// ----------------------------------------------------------------------------
// Moving std-dev band trader
// Sliding price window in a row of cells, exact band test, order and cash.
// ----------------------------------------------------------------------------
// channel  dir  handshake                      payload
// cfg      in   cfg_wen                        cfg_index, cfg_wdata
// s_axis   in   s_axis_tvalid / s_axis_tready  tdata: price; tlast: is_last
// m_axis   out  m_axis_tvalid / m_axis_tready  tdata: order, cash, pnl;
//                                              tuser: final_valid
// One word at a time: accept, then a 7-step sequencer (squares, sums,
// wide multiplies, variance, band, decision, emit) on shared registers.
// The oldest price leaves from cell 0; new prices enter at cell n-1.
// Emit stalls while the output register holds an untaken word.
// Reset clears control state at once; cells need no clearing.
// ----------------------------------------------------------------------------
module moving_stddev_band_trader #(
	parameter int WINDOW_MAX = 256,
	parameter int PRICE_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [mstd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mstd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// price
	input  logic [((PRICE_BITS+7)/8)*8-1:0]     s_axis_tdata,
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// order, cash_after, settled_pnl
	output logic [mstd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// final_valid
	output logic                                m_axis_tuser
);

	import mstd_pkg::*;

	localparam int NW  = $clog2(WINDOW_MAX + 1);
	localparam int AW  = $clog2(WINDOW_MAX);
	localparam int PW  = PRICE_BITS;
	localparam int SW  = PW + NW;
	localparam int QW  = 2 * PW + NW;
	localparam int VW  = 2 * SW;
	localparam int BW  = VW + PP_W;
	localparam int HPW = HOLD_W + PW + 1;

	function automatic logic signed [CASH_W-1:0] sat_cash(input logic signed [CASH_XW-1:0] v);
		if (v > CASH_XMAX) begin
			return CASH_XMAX[CASH_W-1:0];
		end else if (v < CASH_XMIN) begin
			return CASH_XMIN[CASH_W-1:0];
		end else begin
			return v[CASH_W-1:0];
		end
	endfunction

	// config registers
	logic [WLEN_W-1:0]  window_len_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [MULT_W-1:0]  mult_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WLEN_RST;
			limit_q      <= LIMIT_RST;
			mult_q       <= MULT_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_WINDOW_LEN: window_len_q <= cfg_wdata[WLEN_W-1:0];
				CFG_POS_LIMIT:  limit_q      <= cfg_wdata[LIMIT_W-1:0];
				CFG_BAND_MULT:  mult_q       <= cfg_wdata[MULT_W-1:0];
				default: ;
			endcase
		end
	end

	logic cfg_restart;
	assign cfg_restart = cfg_wen && (cfg_index == CFG_WINDOW_LEN);

	logic [NW-1:0] n_eff;
	logic [NW-1:0] n_m1;
	logic [AW-1:0] tail;

	always_comb begin
		if (window_len_q == '0) begin
			n_eff = NW'(1);
		end else if (int'(window_len_q) > WINDOW_MAX) begin
			n_eff = NW'(WINDOW_MAX);
		end else begin
			n_eff = NW'(window_len_q);
		end
	end

	assign n_m1 = n_eff - NW'(1);
	assign tail = n_m1[AW-1:0];

	// sequencer
	state_t state_q, state_nx;
	logic   in_fire;
	logic   emit;
	logic   out_valid_q;
	logic   full_q;
	logic   last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx      = state_q;
		s_axis_tready = 1'b0;
		emit          = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = arst_n;
				if (s_axis_tvalid) begin
					state_nx = ST_SQ;
				end
			end
			ST_SQ:     state_nx = ST_ACC;
			ST_ACC:    state_nx = ST_MUL;
			ST_MUL:    state_nx = ST_VAR;
			ST_VAR:    state_nx = ST_BAND;
			ST_BAND:   state_nx = ST_DECIDE;
			ST_DECIDE: state_nx = ST_EMIT;
			ST_EMIT: begin
				if (full_q || last_q) begin
					if (!out_valid_q || m_axis_tready) begin
						emit     = 1'b1;
						state_nx = ST_IDLE;
					end
				end else begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	assign in_fire = s_axis_tvalid && s_axis_tready;

	// window cells
	logic [PW-1:0] in_price;
	logic [PW-1:0] cell_val [WINDOW_MAX];

	assign in_price = s_axis_tdata[PW-1:0];

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic [PW-1:0] nxt;
		if (i == WINDOW_MAX - 1) begin : g_end
			assign nxt = in_price;
		end else begin : g_mid
			assign nxt = cell_val[i+1];
		end
		mstd_cell #(
			.PW  (PW),
			.AW  (AW),
			.IDX (i)
		) u_cell (
			.clk      (clk),
			.shift    (in_fire),
			.tail     (tail),
			.price_in (in_price),
			.next_in  (nxt),
			.value    (cell_val[i])
		);
	end

	// working registers
	logic [PW-1:0]          price_q;
	logic [PW-1:0]          old_q;
	logic                   was_full_q;
	logic [2*PW-1:0]        psq_q;
	logic [2*PW-1:0]        osq_q;
	logic [SW-1:0]          np_q;
	logic [SW-1:0]          dabs_q;
	logic                   up_q;
	logic                   dn_q;
	logic [VW-1:0]          ssq_q;
	logic [VW-1:0]          d2_q;
	logic [VW-1:0]          nq_q;
	logic [VW-1:0]          var_q;
	logic [PP_W-1:0]        pp_q;
	logic [BW-1:0]          band_q;
	logic [ORDER_W-1:0]     order_q;

	// running state
	logic [NW-1:0]               fill_q;
	logic [SW-1:0]               sum_q;
	logic [QW-1:0]               sumsq_q;
	logic signed [HOLD_W-1:0]    holding_q;
	logic signed [CASH_W-1:0]    cash_q;

	logic                        wide_ok;
	logic                        buy;
	logic                        sell;
	logic signed [HOLD_W-1:0]    lim_s;
	logic signed [CASH_XW-1:0]   cash_x;
	logic signed [CASH_XW-1:0]   price_x;
	logic signed [HPW-1:0]       hp;
	logic signed [CASH_W-1:0]    pnl;

	assign lim_s   = $signed({1'b0, limit_q});
	assign wide_ok = BW'(d2_q) >= band_q;
	assign buy     = full_q && up_q && wide_ok && (holding_q < lim_s);
	assign sell    = full_q && !buy && dn_q && wide_ok && (holding_q > -lim_s);
	assign cash_x  = CASH_XW'(cash_q);
	assign price_x = $signed(CASH_XW'(price_q));
	assign hp      = HPW'(holding_q) * HPW'($signed({1'b0, price_q}));
	assign pnl     = sat_cash(cash_x + CASH_XW'(hp));

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					price_q    <= in_price;
					last_q     <= s_axis_tlast;
					old_q      <= cell_val[0];
					was_full_q <= fill_q >= n_eff;
				end
			end
			ST_SQ: begin
				psq_q <= price_q * price_q;
				osq_q <= old_q * old_q;
				np_q  <= SW'(n_eff) * SW'(price_q);
			end
			ST_ACC: begin
				ssq_q  <= VW'(sum_q) * VW'(sum_q);
				up_q   <= np_q >= sum_q;
				dn_q   <= np_q <= sum_q;
				dabs_q <= (np_q >= sum_q) ? (np_q - sum_q) : (sum_q - np_q);
				full_q <= fill_q >= n_eff;
			end
			ST_MUL: begin
				d2_q <= VW'(dabs_q) * VW'(dabs_q);
				nq_q <= VW'(n_eff) * VW'(sumsq_q);
			end
			ST_VAR: begin
				var_q <= nq_q - ssq_q;
				pp_q  <= PP_W'(mult_q) * PP_W'(mult_q);
			end
			ST_BAND: begin
				band_q <= BW'(var_q) * BW'(pp_q);
			end
			ST_DECIDE: begin
				order_q <= buy ? ORD_BUY : (sell ? ORD_SELL : ORD_NONE);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			sum_q     <= '0;
			sumsq_q   <= '0;
			holding_q <= '0;
			cash_q    <= '0;
		end else begin
			if (cfg_restart) begin
				fill_q  <= '0;
				sum_q   <= '0;
				sumsq_q <= '0;
			end
			case (state_q)
				ST_SQ: begin
					sum_q <= sum_q + SW'(price_q) - (was_full_q ? SW'(old_q) : '0);
					if (!was_full_q) begin
						fill_q <= fill_q + NW'(1);
					end
				end
				ST_ACC: begin
					sumsq_q <= sumsq_q + QW'(psq_q) - (was_full_q ? QW'(osq_q) : '0);
				end
				ST_DECIDE: begin
					if (buy) begin
						cash_q    <= sat_cash(cash_x - price_x);
						holding_q <= holding_q + HOLD_W'(1);
					end else if (sell) begin
						cash_q    <= sat_cash(cash_x + price_x);
						holding_q <= holding_q - HOLD_W'(1);
					end
				end
				ST_EMIT: begin
					if (emit && last_q) begin
						fill_q    <= '0;
						sum_q     <= '0;
						sumsq_q   <= '0;
						holding_q <= '0;
						cash_q    <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// output register
	logic [ORDER_W-1:0]       out_order_q;
	logic signed [CASH_W-1:0] out_cash_q;
	logic                     out_final_q;
	logic signed [CASH_W-1:0] out_pnl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_order_q <= order_q;
			out_cash_q  <= cash_q;
			out_final_q <= last_q;
			out_pnl_q   <= last_q ? pnl : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_pnl_q, out_cash_q, out_order_q};
	assign m_axis_tuser  = out_final_q;

endmodule

// ===== rtl/core/mstd_cell.sv =====
// ----------------------------------------------------------------------------
// Window cell
// One price slot; shifts toward cell 0 or takes the new price at the tail.
// ----------------------------------------------------------------------------
module mstd_cell #(
	parameter int PW  = 24,
	parameter int AW  = 8,
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          shift,
	input  logic [AW-1:0] tail,
	input  logic [PW-1:0] price_in,
	input  logic [PW-1:0] next_in,
	output logic [PW-1:0] value
);

	logic [PW-1:0] value_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			value_q <= (tail == AW'(IDX)) ? price_in : next_in;
		end
	end

	assign value = value_q;

endmodule

// ===== rtl/core/mstd_checker.sv =====
// ----------------------------------------------------------------------------
// Band trader port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`include "moving_stddev_band_trader_defines.svh"

module mstd_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [mstd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                             m_axis_tuser
);

	import mstd_pkg::*;

	`MSTD_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output word changed")

	`MSTD_ASSERT_IMP(a_order_code, m_axis_tvalid, m_axis_tdata[ORDER_W-1:0] == ORD_NONE || m_axis_tdata[ORDER_W-1:0] == ORD_BUY || m_axis_tdata[ORDER_W-1:0] == ORD_SELL, "bad order code")

	`MSTD_ASSERT_IMP(a_pnl_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[ORDER_W+2*CASH_W-1 -: CASH_W] == '0, "pnl nonzero on non-final word")

	`MSTD_ASSERT_NXT(a_one_word, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while a word is in work")

endmodule

bind moving_stddev_band_trader mstd_checker u_mstd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
